@@ hw/rtl/sffa_pkg.sv @@
// Shared types and constants for the submesh first-fit allocator.
`timescale 1ns / 1ps

package sffa_pkg;

  localparam int unsigned MAX_GRID_X_DEFAULT = 16;
  localparam int unsigned MAX_GRID_Y_DEFAULT = 16;

  localparam int unsigned GRID_DIM_W = 5;
  localparam int unsigned REQ_DIM_W  = 5;
  localparam int unsigned COORD_W    = 8;
  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CFG_DATA_W = 8;
  localparam int unsigned IN_DATA_W  = 32;
  localparam int unsigned OUT_DATA_W = 16;

  localparam logic [GRID_DIM_W-1:0] GRID_DIM_X_RESET = 5'd16;
  localparam logic [GRID_DIM_W-1:0] GRID_DIM_Y_RESET = 5'd16;

  localparam logic [CFG_IDX_W-1:0] REG_GRID_DIM_X    = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_DIM_Y    = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_ORIGIN_X = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_ORIGIN_Y = 8'd3;

  localparam logic MODE_RELEASE = 1'b1;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_TOO_BIG = 2'd1,
    ST_NO_FIT  = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_ACC_RD,
    S_ACC_WAIT,
    S_SCAN,
    S_MK_RD,
    S_MK_WR,
    S_DONE
  } state_t;

  typedef struct packed {
    logic    idle;
    logic    load_req;
    logic    acc_start;
    logic    rd;
    logic    acc_upd;
    logic    ox_inc;
    logic    oy_inc;
    logic    mark_start;
    logic    wr;
    logic    res_load;
    status_t code;
  } cmd_t;

  typedef struct packed {
    logic is_release;
    logic too_big;
    logic zero_size;
    logic last_acc;
    logic win_free;
    logic ox_fits;
    logic ox_next_fits;
    logic oy_next_fits;
    logic last_mark;
    logic out_free;
  } stat_t;

endpackage

@@ hw/rtl/sffa_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module sffa_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ hw/rtl/sffa_ctrl.sv @@
// Sequencing state machine for allocate scans and release sweeps.
`timescale 1ns / 1ps

module sffa_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  sffa_pkg::stat_t stat,
  output sffa_pkg::cmd_t  cmd
);

  import sffa_pkg::*;

  state_t  state;
  state_t  state_next;
  status_t code;
  status_t code_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      code  <= ST_OK;
    end else begin
      state <= state_next;
      code  <= code_next;
    end
  end

  always_comb begin
    state_next = state;
    code_next  = code;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (stat.is_release) begin
          state_next = S_MK_RD;
        end else if (stat.too_big) begin
          state_next = S_DONE;
          code_next  = ST_TOO_BIG;
        end else if (stat.zero_size) begin
          state_next = S_DONE;
          code_next  = ST_OK;
        end else begin
          state_next = S_ACC_RD;
        end
      end
      S_ACC_RD: state_next = S_ACC_WAIT;
      S_ACC_WAIT: begin
        state_next = stat.last_acc ? S_SCAN : S_ACC_RD;
      end
      S_SCAN: begin
        if (stat.win_free) begin
          state_next = S_MK_RD;
        end else if (stat.ox_next_fits) begin
          state_next = S_SCAN;
        end else if (stat.oy_next_fits) begin
          state_next = S_ACC_RD;
        end else begin
          state_next = S_DONE;
          code_next  = ST_NO_FIT;
        end
      end
      S_MK_RD: state_next = S_MK_WR;
      S_MK_WR: begin
        if (stat.last_mark) begin
          state_next = S_DONE;
          code_next  = ST_OK;
        end else begin
          state_next = S_MK_RD;
        end
      end
      S_DONE: begin
        if (stat.out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    cmd.code = code;
    case (state)
      S_IDLE: begin
        cmd.idle     = 1'b1;
        cmd.load_req = in_valid;
      end
      S_CHECK: begin
        cmd.mark_start = stat.is_release;
        cmd.acc_start  = !stat.is_release && !stat.too_big && !stat.zero_size;
      end
      S_ACC_RD:   cmd.rd = 1'b1;
      S_ACC_WAIT: cmd.acc_upd = 1'b1;
      S_SCAN: begin
        if (stat.win_free) begin
          cmd.mark_start = 1'b1;
        end else if (stat.ox_next_fits) begin
          cmd.ox_inc = 1'b1;
        end else if (stat.oy_next_fits) begin
          cmd.oy_inc = 1'b1;
        end
      end
      S_MK_RD: cmd.rd = 1'b1;
      S_MK_WR: cmd.wr = 1'b1;
      S_DONE:  cmd.res_load = stat.out_free;
      default: cmd = '0;
    endcase
  end

endmodule

@@ hw/rtl/sffa_dp.sv @@
// Datapath: grid registers, free map rows, window scan counters and result register.
`timescale 1ns / 1ps

module sffa_dp #(
  parameter int unsigned MAX_GRID_X = sffa_pkg::MAX_GRID_X_DEFAULT,
  parameter int unsigned MAX_GRID_Y = sffa_pkg::MAX_GRID_Y_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [sffa_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [sffa_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                                in_user,
  input  logic [sffa_pkg::IN_DATA_W-1:0]      in_data,
  input  sffa_pkg::cmd_t                      cmd,
  output sffa_pkg::stat_t                     stat,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [1:0]                          out_user,
  output logic [sffa_pkg::OUT_DATA_W-1:0]     out_data
);

  import sffa_pkg::*;

  localparam int unsigned MAX_DIM = (MAX_GRID_X > MAX_GRID_Y) ? MAX_GRID_X : MAX_GRID_Y;
  localparam int unsigned NW      = $clog2(MAX_DIM + (2 ** REQ_DIM_W) + 1);
  localparam int unsigned AW      = $clog2(MAX_GRID_Y);
  localparam int unsigned PW      = COORD_W + 2;

  logic [GRID_DIM_W-1:0] grid_dim_x;
  logic [GRID_DIM_W-1:0] grid_dim_y;
  logic [COORD_W-1:0]    grid_origin_x;
  logic [COORD_W-1:0]    grid_origin_y;

  logic                  mode;
  logic [REQ_DIM_W-1:0]  req_dim_x;
  logic [REQ_DIM_W-1:0]  req_dim_y;
  logic [COORD_W-1:0]    release_origin_x;
  logic [COORD_W-1:0]    release_origin_y;

  logic [NW-1:0]         ox;
  logic [NW-1:0]         oy;
  logic [NW-1:0]         row;
  logic [MAX_GRID_X-1:0] acc;
  logic [MAX_GRID_Y-1:0] row_valid;
  logic                  rd_valid;
  logic [MAX_GRID_X-1:0] ram_q;
  logic [MAX_GRID_X-1:0] row_eff;
  logic [MAX_GRID_X-1:0] alloc_mask;
  logic [MAX_GRID_X-1:0] rel_mask;
  logic [MAX_GRID_X-1:0] row_wdata;
  logic                  row_in;
  logic [NW-1:0]         gw;
  logic [NW-1:0]         gh;
  logic [NW-1:0]         rw;
  logic [NW-1:0]         rh;
  status_t               out_status;
  logic [COORD_W-1:0]    out_x;
  logic [COORD_W-1:0]    out_y;

  always_comb begin
    if (grid_dim_x == '0) begin
      gw = NW'(1);
    end else if (NW'(grid_dim_x) > NW'(MAX_GRID_X)) begin
      gw = NW'(MAX_GRID_X);
    end else begin
      gw = NW'(grid_dim_x);
    end
    if (grid_dim_y == '0) begin
      gh = NW'(1);
    end else if (NW'(grid_dim_y) > NW'(MAX_GRID_Y)) begin
      gh = NW'(MAX_GRID_Y);
    end else begin
      gh = NW'(grid_dim_y);
    end
  end

  assign rw = NW'(req_dim_x);
  assign rh = NW'(req_dim_y);

  // Rows never written since the last grid change read as all free.
  assign row_eff = rd_valid ? ram_q : '1;

  always_comb begin
    for (int c = 0; c < MAX_GRID_X; c++) begin
      alloc_mask[c] = (NW'(c) >= ox) && (NW'(c) < ox + rw);
      rel_mask[c]   = (NW'(c) < gw)
                   && (PW'(grid_origin_x) + PW'(c) >= PW'(release_origin_x))
                   && (PW'(grid_origin_x) + PW'(c) < PW'(release_origin_x) + PW'(req_dim_x));
    end
  end

  assign row_in = (PW'(grid_origin_y) + PW'(row) >= PW'(release_origin_y))
               && (PW'(grid_origin_y) + PW'(row) < PW'(release_origin_y) + PW'(req_dim_y));

  always_comb begin
    if (mode == MODE_RELEASE) begin
      row_wdata = row_in ? (row_eff | rel_mask) : row_eff;
    end else begin
      row_wdata = row_eff & ~alloc_mask;
    end
  end

  sffa_ram #(
    .WIDTH (MAX_GRID_X),
    .DEPTH (MAX_GRID_Y)
  ) u_map (
    .clk   (clk),
    .we    (cmd.wr),
    .waddr (row[AW-1:0]),
    .wdata (row_wdata),
    .re    (cmd.rd),
    .raddr (row[AW-1:0]),
    .rdata (ram_q)
  );

  always_comb begin
    stat.is_release   = (mode == MODE_RELEASE);
    stat.too_big      = (rw > gw) || (rh > gh);
    stat.zero_size    = (req_dim_x == '0) || (req_dim_y == '0);
    stat.last_acc     = (row + NW'(1)) == (oy + rh);
    stat.win_free     = (acc & alloc_mask) == alloc_mask;
    stat.ox_fits      = (ox + rw) <= gw;
    stat.ox_next_fits = (ox + NW'(1) + rw) <= gw;
    stat.oy_next_fits = (oy + NW'(1) + rh) <= gh;
    stat.last_mark    = (mode == MODE_RELEASE) ? ((row + NW'(1)) == gh)
                                               : ((row + NW'(1)) == (oy + rh));
    stat.out_free     = !out_valid || out_ready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_dim_x    <= GRID_DIM_X_RESET;
      grid_dim_y    <= GRID_DIM_Y_RESET;
      grid_origin_x <= '0;
      grid_origin_y <= '0;
      row_valid     <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_GRID_DIM_X: begin
            grid_dim_x <= cfg_data[GRID_DIM_W-1:0];
            row_valid  <= '0;
          end
          REG_GRID_DIM_Y: begin
            grid_dim_y <= cfg_data[GRID_DIM_W-1:0];
            row_valid  <= '0;
          end
          REG_GRID_ORIGIN_X: begin
            grid_origin_x <= cfg_data[COORD_W-1:0];
            row_valid     <= '0;
          end
          REG_GRID_ORIGIN_Y: begin
            grid_origin_y <= cfg_data[COORD_W-1:0];
            row_valid     <= '0;
          end
          default: ;
        endcase
      end else if (cmd.wr) begin
        row_valid[row[AW-1:0]] <= 1'b1;
      end
      if (cmd.res_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      mode             <= in_user;
      req_dim_x        <= in_data[4:0];
      req_dim_y        <= in_data[9:5];
      release_origin_x <= in_data[17:10];
      release_origin_y <= in_data[25:18];
      ox               <= '0;
      oy               <= '0;
    end
    if (cmd.acc_start) begin
      acc <= '1;
      row <= oy;
      ox  <= '0;
    end else if (cmd.oy_inc) begin
      acc <= '1;
      oy  <= oy + NW'(1);
      row <= oy + NW'(1);
      ox  <= '0;
    end else if (cmd.acc_upd) begin
      acc <= acc & row_eff;
      row <= row + NW'(1);
    end else if (cmd.ox_inc) begin
      ox <= ox + NW'(1);
    end else if (cmd.mark_start) begin
      row <= (mode == MODE_RELEASE) ? '0 : oy;
    end else if (cmd.wr) begin
      row <= row + NW'(1);
    end
    if (cmd.rd) begin
      rd_valid <= row_valid[row[AW-1:0]];
    end
    if (cmd.res_load) begin
      out_status <= cmd.code;
      if (cmd.code == ST_OK && mode != MODE_RELEASE) begin
        out_x <= grid_origin_x + COORD_W'(ox);
        out_y <= grid_origin_y + COORD_W'(oy);
      end else begin
        out_x <= '0;
        out_y <= '0;
      end
    end
  end

  assign out_user = out_status;
  assign out_data = {out_y, out_x};

endmodule

@@ hw/rtl/submesh_first_fit_allocator.sv @@
// Top level of the submesh first-fit allocator.
`timescale 1ns / 1ps

// Channel  Direction  Handshake              Payload
// s_axis   in         tvalid / tready        tuser: mode; tdata: dims and release origin
// m_axis   out        tvalid / tready        tuser: status; tdata: group origin
// cfg      in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
// A release reads and then writes every grid row in turn. Error and zero-size requests
// go straight to the result. An allocate, for each candidate row, combines the window's
// rows through the registered read and then tries the columns in turn, and on a hit
// reads and writes each row of the window to mark it.
// Reset is immediate: per-row valid bits make unwritten rows read as free.
// An untaken result waits in an output register; the next word then runs and holds input.

module submesh_first_fit_allocator #(
  parameter int unsigned MAX_GRID_X = sffa_pkg::MAX_GRID_X_DEFAULT,
  parameter int unsigned MAX_GRID_Y = sffa_pkg::MAX_GRID_Y_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // req_dim_x, req_dim_y, release_origin_x, release_origin_y, zero pad
  input  logic [sffa_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  // mode
  input  logic                             s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // group_origin_x, group_origin_y
  output logic [sffa_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
  // status
  output logic [1:0]                       m_axis_tuser,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [sffa_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [sffa_pkg::CFG_DATA_W-1:0]  cfg_data
);

  import sffa_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  assign s_axis_tready = cmd.idle;
  assign cfg_ready     = cmd.idle;

  sffa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .stat     (stat),
    .cmd      (cmd)
  );

  sffa_dp #(
    .MAX_GRID_X (MAX_GRID_X),
    .MAX_GRID_Y (MAX_GRID_Y)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_user   (s_axis_tuser),
    .in_data   (s_axis_tdata),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_user  (m_axis_tuser),
    .out_data  (m_axis_tdata)
  );

  a_res_slot_free: assert property (@(posedge clk) disable iff (rst)
    cmd.res_load |-> (!m_axis_tvalid || m_axis_tready))
    else $error("result loaded over an untaken word");

  a_window_inside: assert property (@(posedge clk) disable iff (rst)
    (cmd.mark_start && !stat.is_release) |-> (stat.ox_fits && stat.win_free))
    else $error("allocated window not inside grid or not free");

  a_fail_origin_zero: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser != ST_OK) |-> (m_axis_tdata == '0))
    else $error("nonzero origin on a failed request");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    cmd.load_req |=> !s_axis_tready)
    else $error("input accepted again while a request is in progress");

endmodule

@@ tb/sv/tb_submesh_first_fit_allocator.sv @@
// Self-checking testbench for the submesh first-fit allocator.
`timescale 1ns / 1ps

module tb_submesh_first_fit_allocator;
  import sffa_pkg::*;

  localparam int MAP_STRIDE = MAX_GRID_X_DEFAULT;
  localparam int MAP_DEPTH = MAX_GRID_X_DEFAULT * MAX_GRID_Y_DEFAULT;
  localparam int DIR_ROWS = 20;
  localparam int NUM_PHASES = 11;
  localparam int RAND_PER_PHASE = 112;
  localparam int LONG_HOLD = 600;
  localparam int CYCLE_LIMIT = 3_000_000;
  localparam logic MODE_ALLOC = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LOW = 8'd4;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_TOP = 8'hFF;
  localparam logic [CFG_IDX_W-1:0] GRID_REGS [4] = '{REG_GRID_DIM_X, REG_GRID_DIM_Y,
                                                     REG_GRID_ORIGIN_X, REG_GRID_ORIGIN_Y};

  typedef struct {
    status_t    status;
    logic [7:0] x;
    logic [7:0] y;
  } grant_t;

  typedef struct {
    logic       mode;
    logic [4:0] w;
    logic [4:0] h;
    logic [7:0] x;
    logic [7:0] y;
    bit         typed;
    status_t    st;
    logic [7:0] ex;
    logic [7:0] ey;
  } req_row_t;

  typedef struct {
    logic [7:0] x;
    logic [7:0] y;
    logic [4:0] w;
    logic [4:0] h;
  } window_t;

  logic clk;
  logic rst;
  logic s_axis_tvalid;
  logic s_axis_tready;
  logic [IN_DATA_W-1:0] s_axis_tdata;
  logic s_axis_tuser;
  logic m_axis_tvalid;
  logic m_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic [1:0] m_axis_tuser;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  bit tile_free [MAP_DEPTH];
  logic [4:0] cfg_dim_x = GRID_DIM_X_RESET;
  logic [4:0] cfg_dim_y = GRID_DIM_Y_RESET;
  logic [7:0] cfg_org_x = 8'd0;
  logic [7:0] cfg_org_y = 8'd0;

  grant_t grant_q [$];
  window_t live_windows [$];
  req_row_t dir_tab [DIR_ROWS];
  grant_t want;
  int mismatches = 0;
  int cycles = 0;
  int p;
  int n;
  bit gap_on = 1'b1;
  bit stall_on = 1'b1;
  bit long_hold_pending = 1'b0;

  submesh_first_fit_allocator u_top (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic int eff_dim(logic [4:0] v, int maxd);
    if (v == 5'd0) return 1;
    if (int'(v) > maxd) return maxd;
    return int'(v);
  endfunction

  function automatic grant_t serve_request(req_row_t r);
    grant_t g;
    int gw, gh, rw, rh, bx, by, x, y, ox, oy, i, j;
    bit fits;
    g.status = ST_OK;
    g.x = 8'd0;
    g.y = 8'd0;
    gw = eff_dim(cfg_dim_x, MAX_GRID_X_DEFAULT);
    gh = eff_dim(cfg_dim_y, MAX_GRID_Y_DEFAULT);
    rw = r.w;
    rh = r.h;
    bx = cfg_org_x;
    by = cfg_org_y;
    if (r.mode == MODE_RELEASE) begin
      for (j = 0; j < rh; j++) begin
        y = int'(r.y) + j;
        if (y < by || y - by >= gh) continue;
        for (i = 0; i < rw; i++) begin
          x = int'(r.x) + i;
          if (x < bx || x - bx >= gw) continue;
          tile_free[(y - by) * MAP_STRIDE + (x - bx)] = 1'b1;
        end
      end
      return g;
    end
    if (rw > gw || rh > gh) begin
      g.status = ST_TOO_BIG;
      return g;
    end
    for (oy = 0; oy + rh <= gh; oy++) begin
      for (ox = 0; ox + rw <= gw; ox++) begin
        fits = 1'b1;
        for (j = 0; j < rh; j++)
          for (i = 0; i < rw; i++)
            if (!tile_free[(oy + j) * MAP_STRIDE + ox + i]) fits = 1'b0;
        if (fits) begin
          for (j = 0; j < rh; j++)
            for (i = 0; i < rw; i++)
              tile_free[(oy + j) * MAP_STRIDE + ox + i] = 1'b0;
          g.x = 8'(bx + ox);
          g.y = 8'(by + oy);
          return g;
        end
      end
    end
    g.status = ST_NO_FIT;
    return g;
  endfunction

  function automatic req_row_t pick_request();
    req_row_t r;
    window_t w;
    int gw, gh, k, sel;
    gw = eff_dim(cfg_dim_x, MAX_GRID_X_DEFAULT);
    gh = eff_dim(cfg_dim_y, MAX_GRID_Y_DEFAULT);
    r.typed = 1'b0;
    r.st = ST_OK;
    r.ex = 8'd0;
    r.ey = 8'd0;
    r.x = 8'($urandom);
    r.y = 8'($urandom);
    sel = $urandom_range(0, 99);
    if (live_windows.size() > 0 && sel < 35) begin
      k = $urandom_range(0, live_windows.size() - 1);
      w = live_windows[k];
      live_windows.delete(k);
      r.mode = MODE_RELEASE;
      r.x = w.x;
      r.y = w.y;
      r.w = w.w;
      r.h = w.h;
    end else if (sel < 45) begin
      r.mode = MODE_RELEASE;
      if ($urandom_range(0, 3) != 0) begin
        r.x = 8'(int'(cfg_org_x) + int'($urandom_range(0, gw + 3)) - 2);
        r.y = 8'(int'(cfg_org_y) + int'($urandom_range(0, gh + 3)) - 2);
      end
      r.w = ($urandom_range(0, 3) == 0) ? 5'($urandom_range(0, 31)) : 5'($urandom_range(1, 4));
      r.h = ($urandom_range(0, 3) == 0) ? 5'($urandom_range(0, 31)) : 5'($urandom_range(1, 4));
    end else begin
      r.mode = MODE_ALLOC;
      sel = $urandom_range(0, 99);
      if (sel < 5) begin
        r.w = 5'($urandom_range(0, gw));
        r.h = 5'($urandom_range(0, gh));
        if ($urandom_range(0, 1) == 0) r.w = 5'd0;
        else r.h = 5'd0;
      end else if (sel < 12) begin
        r.w = 5'($urandom_range(gw + 1, 31));
        r.h = 5'($urandom_range(0, 31));
        if ($urandom_range(0, 1) == 0) begin
          r.h = r.w;
          r.w = 5'($urandom_range(0, 31));
          if (int'(r.h) <= gh) r.h = 5'($urandom_range(gh + 1, 31));
        end
      end else if (sel < 25) begin
        r.w = 5'($urandom_range(1, gw));
        r.h = 5'($urandom_range(1, gh));
      end else begin
        r.w = 5'($urandom_range(1, (gw < 4) ? gw : 4));
        r.h = 5'($urandom_range(1, (gh < 4) ? gh : 4));
      end
    end
    return r;
  endfunction

  task automatic offer_request(input req_row_t r);
    grant_t got;
    if (gap_on && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= r.mode;
    s_axis_tdata <= {6'b0, r.y, r.x, r.h, r.w};
    do @(posedge clk); while (!s_axis_tready);
    got = serve_request(r);
    if (r.mode == MODE_ALLOC && got.status == ST_OK && r.w != 5'd0 && r.h != 5'd0)
      live_windows.push_back('{got.x, got.y, r.w, r.h});
    if (r.typed) grant_q.push_back('{r.st, r.ex, r.ey});
    else grant_q.push_back(got);
  endtask

  task automatic write_grid_reg(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_GRID_DIM_X: cfg_dim_x = d[4:0];
      REG_GRID_DIM_Y: cfg_dim_y = d[4:0];
      REG_GRID_ORIGIN_X: cfg_org_x = d;
      REG_GRID_ORIGIN_Y: cfg_org_y = d;
      default: return;
    endcase
    foreach (tile_free[t]) tile_free[t] = 1'b1;
    live_windows.delete();
  endtask

  task automatic program_grid(input int phase);
    int k, first;
    logic [CFG_IDX_W-1:0] idx;
    logic [CFG_DATA_W-1:0] d;
    case (phase)
      1: begin
        write_grid_reg(REG_GRID_DIM_X, 8'd1);
        write_grid_reg(REG_GRID_DIM_Y, 8'd1);
        write_grid_reg(REG_GRID_ORIGIN_X, 8'd0);
        write_grid_reg(REG_GRID_ORIGIN_Y, 8'd0);
      end
      2: begin
        write_grid_reg(REG_GRID_DIM_X, 8'd16);
        write_grid_reg(REG_GRID_DIM_Y, 8'd16);
        write_grid_reg(REG_GRID_ORIGIN_X, 8'd240);
        write_grid_reg(REG_GRID_ORIGIN_Y, 8'd240);
      end
      3: begin
        write_grid_reg(REG_GRID_DIM_X, 8'h00);
        write_grid_reg(REG_GRID_DIM_Y, 8'hFF);
        write_grid_reg(REG_GRID_ORIGIN_X, 8'hFF);
        write_grid_reg(REG_GRID_ORIGIN_Y, 8'hFF);
      end
      4: begin
        write_grid_reg(REG_UNUSED_LOW, 8'h00);
        write_grid_reg(REG_UNUSED_TOP, 8'hFF);
      end
      default: begin
        first = $urandom_range(0, 3);
        for (k = 0; k < 4; k++) begin
          idx = GRID_REGS[k];
          if (idx == REG_GRID_DIM_X || idx == REG_GRID_DIM_Y) begin
            case ($urandom_range(0, 9))
              0: d = 8'd0;
              1: d = 8'($urandom_range(17, 255));
              default: d = {3'($urandom), 5'($urandom_range(1, 16))};
            endcase
          end else begin
            d = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(240, 255)) : 8'($urandom);
          end
          if (k == first || $urandom_range(0, 2) != 0) write_grid_reg(idx, d);
        end
      end
    endcase
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_results();
    do @(posedge clk); while (grant_q.size() != 0);
  endtask

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (grant_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected word: status %0d origin (%0d,%0d)", m_axis_tuser,
                   m_axis_tdata[7:0], m_axis_tdata[15:8]);
      end else begin
        want = grant_q.pop_front();
        if (m_axis_tuser != want.status || m_axis_tdata[7:0] != want.x ||
            m_axis_tdata[15:8] != want.y) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected status %0d origin (%0d,%0d), got status %0d origin (%0d,%0d)",
                     want.status, want.x, want.y, m_axis_tuser, m_axis_tdata[7:0],
                     m_axis_tdata[15:8]);
        end
      end
    end
  end

  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold_pending) begin
        long_hold_pending = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        m_axis_tready <= 1'b1;
      end else if (stall_on && $urandom_range(0, 5) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk);
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  initial begin
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    foreach (tile_free[t]) tile_free[t] = 1'b1;
    dir_tab = '{
      '{MODE_ALLOC,   5'd16, 5'd16, 8'd0,   8'd0,   1'b1, ST_OK,      8'd0, 8'd0},
      '{MODE_ALLOC,   5'd1,  5'd1,  8'd0,   8'd0,   1'b1, ST_NO_FIT,  8'd0, 8'd0},
      '{MODE_ALLOC,   5'd17, 5'd1,  8'd0,   8'd0,   1'b1, ST_TOO_BIG, 8'd0, 8'd0},
      '{MODE_ALLOC,   5'd1,  5'd31, 8'd0,   8'd0,   1'b1, ST_TOO_BIG, 8'd0, 8'd0},
      '{MODE_RELEASE, 5'd16, 5'd16, 8'd0,   8'd0,   1'b1, ST_OK,      8'd0, 8'd0},
      '{MODE_ALLOC,   5'd0,  5'd5,  8'd0,   8'd0,   1'b1, ST_OK,      8'd0, 8'd0},
      '{MODE_ALLOC,   5'd5,  5'd0,  8'd0,   8'd0,   1'b1, ST_OK,      8'd0, 8'd0},
      '{MODE_ALLOC,   5'd4,  5'd4,  8'd0,   8'd0,   1'b1, ST_OK,      8'd0, 8'd0},
      '{MODE_ALLOC,   5'd4,  5'd4,  8'd0,   8'd0,   1'b1, ST_OK,      8'd4, 8'd0},
      '{MODE_ALLOC,   5'd16, 5'd1,  8'd0,   8'd0,   1'b1, ST_OK,      8'd0, 8'd4},
      '{MODE_RELEASE, 5'd31, 5'd31, 8'd250, 8'd250, 1'b1, ST_OK,      8'd0, 8'd0},
      '{MODE_RELEASE, 5'd4,  5'd4,  8'd2,   8'd2,   1'b1, ST_OK,      8'd0, 8'd0},
      '{MODE_ALLOC,   5'd2,  5'd2,  8'd0,   8'd0,   1'b0, ST_OK,      8'd0, 8'd0},
      '{MODE_ALLOC,   5'd8,  5'd8,  8'd0,   8'd0,   1'b0, ST_OK,      8'd0, 8'd0},
      '{MODE_ALLOC,   5'd16, 5'd16, 8'd0,   8'd0,   1'b1, ST_NO_FIT,  8'd0, 8'd0},
      '{MODE_RELEASE, 5'd1,  5'd1,  8'd255, 8'd255, 1'b1, ST_OK,      8'd0, 8'd0},
      '{MODE_ALLOC,   5'd1,  5'd16, 8'd0,   8'd0,   1'b0, ST_OK,      8'd0, 8'd0},
      '{MODE_RELEASE, 5'd31, 5'd31, 8'd0,   8'd0,   1'b1, ST_OK,      8'd0, 8'd0},
      '{MODE_ALLOC,   5'd16, 5'd16, 8'd0,   8'd0,   1'b1, ST_OK,      8'd0, 8'd0},
      '{MODE_RELEASE, 5'd16, 5'd16, 8'd0,   8'd0,   1'b1, ST_OK,      8'd0, 8'd0}
    };
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    for (n = 0; n < DIR_ROWS; n++) offer_request(dir_tab[n]);
    s_axis_tvalid <= 1'b0;
    wait_results();

    for (p = 1; p <= NUM_PHASES; p++) begin
      program_grid(p);
      gap_on = (p != NUM_PHASES) && ($urandom_range(0, 2) != 0);
      stall_on = (p != NUM_PHASES) && ($urandom_range(0, 2) != 0);
      for (n = 0; n < RAND_PER_PHASE; n++) begin
        if (p == 2 && n == 20) long_hold_pending = 1'b1;
        if (p == 4 && n == RAND_PER_PHASE / 2) begin
          s_axis_tvalid <= 1'b0;
          wait_results();
        end
        offer_request(pick_request());
      end
      s_axis_tvalid <= 1'b0;
      wait_results();
    end

    repeat (50) @(posedge clk);
    if (mismatches == 0 && grant_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
